// ===== design/thread_scheduler_mutex_queues_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the thread scheduler checker
// ---------------------------------------------------------------------------
`ifndef THREAD_SCHEDULER_MUTEX_QUEUES_MACROS_SVH
`define THREAD_SCHEDULER_MUTEX_QUEUES_MACROS_SVH

// same-cycle implication
`define TSMQ_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("scheduler check failed");

// next-cycle implication
`define TSMQ_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("scheduler check failed");

`endif

// ===== design/tsmq_pkg.sv =====
// ---------------------------------------------------------------------------
// tsmq_pkg
// types, sizes and codes shared by the thread scheduler files
// ---------------------------------------------------------------------------
package tsmq_pkg;

	localparam int NUM_THREADS = 4;
	localparam int NUM_MUTEXES = 4;

	localparam int ID_W       = $clog2(NUM_THREADS + 2);
	localparam int LINK_DEPTH = NUM_THREADS + 1;
	localparam int LINK_AW    = $clog2(LINK_DEPTH);
	localparam int MUTEX_W    = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;

	typedef logic [ID_W-1:0]    id_t;
	typedef logic [MUTEX_W-1:0] mutex_idx_t;

	localparam id_t INIT_ID = id_t'(NUM_THREADS);
	localparam id_t NONE_ID = id_t'(NUM_THREADS + 1);

	typedef enum logic [2:0] {
		OP_SPAWN  = 3'd0,
		OP_YIELD  = 3'd1,
		OP_LOCK   = 3'd2,
		OP_UNLOCK = 3'd3,
		OP_FINISH = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_FREE  = 2'd1,
		STATUS_NO_READY = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] mutex_id;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] running_thread;
		logic [1:0] spawned_thread;
		logic       switched;
	} rsp_t;

	function automatic logic valid_id(id_t id);
		return id <= id_t'(NUM_THREADS);
	endfunction

	// fold a mutex number into range
	function automatic mutex_idx_t mutex_index(logic [1:0] m);
		logic [2:0] v;
		v = {1'b0, m};
		for (int i = 0; i < 3; i++) begin
			if (v >= NUM_MUTEXES) begin
				v = v - 3'(NUM_MUTEXES);
			end
		end
		return mutex_idx_t'(v);
	endfunction

endpackage

// ===== design/tsmq_ram.sv =====
// ---------------------------------------------------------------------------
// tsmq_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module tsmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/thread_scheduler_mutex_queues.sv =====
// ---------------------------------------------------------------------------
// thread_scheduler_mutex_queues
// round-robin thread scheduler with free list, ready queue and mutex wait
// queues, all chained through one link ram
// ---------------------------------------------------------------------------
// the request beat is taken in ST_IDLE, the link ram is read in ST_READ and the result beat
// is registered in ST_EXEC once the result register is free or being drained; no new request
// is taken until then. The link ram read is registered: one link read, at most one link write per op
// reset: the link ram is loaded with the free chain in ST_INIT after arst_n rises;
// req_ready stays low until then
module thread_scheduler_mutex_queues
	import tsmq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

	state_t               state_q;
	logic [LINK_AW-1:0]   init_cnt_q;
	logic [2:0]           op_q;
	mutex_idx_t           m_q;

	id_t                  running_q;
	id_t                  free_head_q;
	id_t                  free_tail_q;
	id_t                  ready_head_q;
	id_t                  ready_tail_q;
	id_t                  wait_head_q [NUM_MUTEXES];
	id_t                  wait_tail_q [NUM_MUTEXES];
	logic                 lock_q      [NUM_MUTEXES];

	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	id_t                  n_running;
	id_t                  n_free_head;
	id_t                  n_free_tail;
	id_t                  n_ready_head;
	id_t                  n_ready_tail;
	id_t                  n_wait_head;
	id_t                  n_wait_tail;
	logic                 n_lock;
	status_t              n_status;
	id_t                  n_spawned;

	id_t                  wh;
	id_t                  wt;
	id_t                  link_rdata;
	id_t                  rd_id;
	logic                 upd_we;
	id_t                  upd_addr;
	id_t                  upd_data;
	logic                 ram_we;
	logic [LINK_AW-1:0]   ram_waddr;
	id_t                  ram_wdata;
	logic                 exec_fire;
	logic                 init_last;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign exec_fire = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);
	assign init_last = (init_cnt_q == LINK_AW'(NUM_THREADS - 2));

	assign wh = wait_head_q[m_q];
	assign wt = wait_tail_q[m_q];

	// head whose link is needed
	always_comb begin
		unique case (op_q)
			OP_SPAWN:  rd_id = free_head_q;
			OP_UNLOCK: rd_id = wh;
			default:   rd_id = ready_head_q;
		endcase
	end

	assign ram_we    = (state_q == ST_INIT) || (exec_fire && upd_we);
	assign ram_waddr = (state_q == ST_INIT) ? init_cnt_q : upd_addr[LINK_AW-1:0];
	assign ram_wdata = (state_q == ST_INIT) ? (id_t'(init_cnt_q) + id_t'(1)) : upd_data;

	tsmq_ram #(
		.WIDTH (ID_W),
		.DEPTH (LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_id[LINK_AW-1:0]),
		.rdata (link_rdata)
	);

	// queue update, one link write at most
	always_comb begin
		n_running    = running_q;
		n_free_head  = free_head_q;
		n_free_tail  = free_tail_q;
		n_ready_head = ready_head_q;
		n_ready_tail = ready_tail_q;
		n_wait_head  = wh;
		n_wait_tail  = wt;
		n_lock       = lock_q[m_q];
		n_status     = STATUS_OK;
		n_spawned    = '0;
		upd_we       = 1'b0;
		upd_addr     = ready_tail_q;
		upd_data     = running_q;

		unique case (op_q)
			OP_SPAWN: begin
				if (!valid_id(free_head_q)) begin
					n_status = STATUS_NO_FREE;
				end else begin
					n_spawned = free_head_q;
					if (free_head_q == free_tail_q) begin
						n_free_head = NONE_ID;
						n_free_tail = NONE_ID;
					end else begin
						n_free_head = link_rdata;
					end
					if (!valid_id(ready_head_q)) begin
						n_ready_head = free_head_q;
					end else begin
						upd_we   = 1'b1;
						upd_addr = ready_tail_q;
						upd_data = free_head_q;
					end
					n_ready_tail = free_head_q;
				end
			end
			OP_YIELD: begin
				if (valid_id(ready_head_q)) begin
					upd_we       = 1'b1;
					upd_addr     = ready_tail_q;
					upd_data     = running_q;
					n_running    = ready_head_q;
					n_ready_tail = running_q;
					n_ready_head = (ready_head_q == ready_tail_q) ? running_q : link_rdata;
				end
			end
			OP_LOCK: begin
				if (!lock_q[m_q]) begin
					n_lock = 1'b1;
				end else if (!valid_id(ready_head_q)) begin
					n_status = STATUS_NO_READY;
				end else begin
					if (!valid_id(wh)) begin
						n_wait_head = running_q;
					end else begin
						upd_we   = 1'b1;
						upd_addr = wt;
						upd_data = running_q;
					end
					n_wait_tail = running_q;
					n_running   = ready_head_q;
					if (ready_head_q == ready_tail_q) begin
						n_ready_head = NONE_ID;
						n_ready_tail = NONE_ID;
					end else begin
						n_ready_head = link_rdata;
					end
				end
			end
			OP_UNLOCK: begin
				if (!valid_id(wh)) begin
					n_lock = 1'b0;
				end else begin
					if (!valid_id(ready_head_q)) begin
						n_ready_head = running_q;
					end else begin
						upd_we   = 1'b1;
						upd_addr = ready_tail_q;
						upd_data = running_q;
					end
					n_ready_tail = running_q;
					n_running    = wh;
					if (wh == wt) begin
						n_wait_head = NONE_ID;
						n_wait_tail = NONE_ID;
					end else begin
						n_wait_head = link_rdata;
					end
				end
			end
			OP_FINISH: begin
				if (!valid_id(ready_head_q)) begin
					n_status = STATUS_NO_READY;
				end else begin
					// the initial thread is dropped, never freed
					if (running_q < INIT_ID) begin
						if (!valid_id(free_head_q)) begin
							n_free_head = running_q;
						end else begin
							upd_we   = 1'b1;
							upd_addr = free_tail_q;
							upd_data = running_q;
						end
						n_free_tail = running_q;
					end
					n_running = ready_head_q;
					if (ready_head_q == ready_tail_q) begin
						n_ready_head = NONE_ID;
						n_ready_tail = NONE_ID;
					end else begin
						n_ready_head = link_rdata;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			init_cnt_q   <= '0;
			running_q    <= INIT_ID;
			free_head_q  <= '0;
			free_tail_q  <= id_t'(NUM_THREADS - 1);
			ready_head_q <= NONE_ID;
			ready_tail_q <= NONE_ID;
			for (int i = 0; i < NUM_MUTEXES; i++) begin
				wait_head_q[i] <= NONE_ID;
				wait_tail_q[i] <= NONE_ID;
				lock_q[i]      <= 1'b0;
			end
			rsp_valid_q  <= 1'b0;
		end else begin
			if (exec_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					init_cnt_q <= init_cnt_q + LINK_AW'(1);
					if (init_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q             <= ST_IDLE;
						running_q           <= n_running;
						free_head_q         <= n_free_head;
						free_tail_q         <= n_free_tail;
						ready_head_q        <= n_ready_head;
						ready_tail_q        <= n_ready_tail;
						wait_head_q[m_q]    <= n_wait_head;
						wait_tail_q[m_q]    <= n_wait_tail;
						lock_q[m_q]         <= n_lock;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q <= req.op;
			m_q  <= mutex_index(req.mutex_id);
		end
		if (exec_fire) begin
			rsp_q.status         <= n_status;
			rsp_q.running_thread <= 3'(n_running);
			rsp_q.spawned_thread <= 2'(n_spawned);
			rsp_q.switched       <= (n_running != running_q);
		end
	end

endmodule

// ===== design/tsmq_checker.sv =====
// ---------------------------------------------------------------------------
// tsmq_checker
// port-level checks on the thread scheduler, bound to the top level
// ---------------------------------------------------------------------------
`include "thread_scheduler_mutex_queues_macros.svh"

module tsmq_checker
	import tsmq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// stalled result beat holds
	`TSMQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// one request in flight at a time
	`TSMQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)

	// a failed op never switches threads
	`TSMQ_ASSERT_NOW(a_fail_no_switch, clk, arst_n, rsp_valid && (rsp.status != STATUS_OK), !rsp.switched)

	// a spawn slot is reported only by a clean spawn
	`TSMQ_ASSERT_NOW(a_spawn_clean, clk, arst_n, rsp_valid && (rsp.spawned_thread != 2'd0), (rsp.status == STATUS_OK) && !rsp.switched)

endmodule

bind thread_scheduler_mutex_queues tsmq_checker u_tsmq_checker (.*);

// ===== tb/sv/thread_scheduler_mutex_queues_tb.sv =====
// ---------------------------------------------------------------------------
// thread_scheduler_mutex_queues_tb
// Self-checking bench for the thread scheduler. A directed opener walks the
// empty-queue errors, slot exhaustion, lock hand-over and the initial thread
// finishing. A weighted random run follows. Every request beat is run
// through a scheduler model kept in the bench, and each response beat is
// checked field by field against the oldest expected beat. Both sides
// idle at random, the response side holds off once for a long stretch,
// and the request side once waits for the pipe to drain.
// ---------------------------------------------------------------------------
module thread_scheduler_mutex_queues_tb
	import tsmq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 36;
	localparam int CALM_LO      = 120;
	localparam int CALM_HI      = 200;
	localparam int HOLD_AT      = 250;
	localparam int HOLD_LEN     = 60;
	localparam int TRAIL_CYCLES = 20;

	localparam int LIST_FREE  = 0;
	localparam int LIST_READY = 1;
	localparam int LIST_WAIT0 = 2;
	localparam int LIST_CNT   = LIST_WAIT0 + NUM_MUTEXES;

	localparam logic [2:0] OP_RSVD_A = 3'd5;
	localparam logic [2:0] OP_RSVD_B = 3'd6;
	localparam logic [2:0] OP_RSVD_C = 3'd7;

	typedef struct packed {
		logic drain;
		req_t r;
	} sched_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	sched_cmd_t pending_cmds[$];
	rsp_t       expected_rsps[$];

	int sent_cnt = 0;
	int recv_cnt = 0;
	int mismatches = 0;
	int cycles = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	// scheduler image
	id_t  sched_link[NUM_THREADS + 1];
	id_t  sched_head[LIST_CNT];
	id_t  sched_tail[LIST_CNT];
	logic sched_lock[NUM_MUTEXES];
	id_t  cur_thread;

	thread_scheduler_mutex_queues u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void sched_clear();
		cur_thread = INIT_ID;
		for (int i = 0; i < NUM_THREADS; i++) begin
			sched_link[i] = (i == NUM_THREADS - 1) ? NONE_ID : id_t'(i + 1);
		end
		sched_link[NUM_THREADS] = NONE_ID;
		for (int q = 0; q < LIST_CNT; q++) begin
			sched_head[q] = NONE_ID;
			sched_tail[q] = NONE_ID;
		end
		sched_head[LIST_FREE] = id_t'(0);
		sched_tail[LIST_FREE] = id_t'(NUM_THREADS - 1);
		for (int m = 0; m < NUM_MUTEXES; m++) begin
			sched_lock[m] = 1'b0;
		end
	endfunction

	function automatic void list_push(input int q, input id_t id);
		if (id > INIT_ID) begin
			return;
		end
		sched_link[id] = NONE_ID;
		if (sched_head[q] > INIT_ID) begin
			sched_head[q] = id;
		end else if (sched_tail[q] <= INIT_ID) begin
			sched_link[sched_tail[q]] = id;
		end
		sched_tail[q] = id;
	endfunction

	function automatic id_t list_pop(input int q);
		id_t id;
		id = sched_head[q];
		if (id > INIT_ID) begin
			return NONE_ID;
		end
		sched_head[q] = sched_link[id];
		if (sched_head[q] > INIT_ID) begin
			sched_tail[q] = NONE_ID;
		end
		sched_link[id] = NONE_ID;
		return id;
	endfunction

	function automatic rsp_t predict_outcome(input req_t r);
		rsp_t res;
		id_t prior;
		id_t id;
		int m;
		prior = cur_thread;
		m = int'(r.mutex_id) % NUM_MUTEXES;
		res = '0;
		res.status = STATUS_OK;
		case (r.op)
			OP_SPAWN: begin
				if (sched_head[LIST_FREE] > INIT_ID) begin
					res.status = STATUS_NO_FREE;
				end else begin
					id = list_pop(LIST_FREE);
					list_push(LIST_READY, id);
					res.spawned_thread = id[1:0];
				end
			end
			OP_YIELD: begin
				list_push(LIST_READY, cur_thread);
				cur_thread = list_pop(LIST_READY);
			end
			OP_LOCK: begin
				if (sched_lock[m]) begin
					if (sched_head[LIST_READY] > INIT_ID) begin
						res.status = STATUS_NO_READY;
					end else begin
						list_push(LIST_WAIT0 + m, cur_thread);
						cur_thread = list_pop(LIST_READY);
					end
				end else begin
					sched_lock[m] = 1'b1;
				end
			end
			OP_UNLOCK: begin
				if (sched_head[LIST_WAIT0 + m] <= INIT_ID) begin
					list_push(LIST_READY, cur_thread);
					cur_thread = list_pop(LIST_WAIT0 + m);
				end else begin
					sched_lock[m] = 1'b0;
				end
			end
			OP_FINISH: begin
				if (sched_head[LIST_READY] > INIT_ID) begin
					res.status = STATUS_NO_READY;
				end else begin
					if (cur_thread < INIT_ID) begin
						list_push(LIST_FREE, cur_thread);
					end
					cur_thread = list_pop(LIST_READY);
				end
			end
			default: begin
			end
		endcase
		res.running_thread = cur_thread;
		res.switched = (cur_thread != prior);
		return res;
	endfunction

	function automatic void push_cmd(input logic [2:0] op, input logic [1:0] m,
			input logic drain);
		sched_cmd_t c;
		c.drain = drain;
		c.r.op = op;
		c.r.mutex_id = m;
		pending_cmds.push_back(c);
	endfunction

	function automatic logic [2:0] pick_op();
		int p;
		p = $urandom_range(99);
		if (p < 20) begin
			return OP_SPAWN;
		end else if (p < 40) begin
			return OP_YIELD;
		end else if (p < 65) begin
			return OP_LOCK;
		end else if (p < 85) begin
			return OP_UNLOCK;
		end else if (p < 95) begin
			return OP_FINISH;
		end
		return 3'($urandom_range(OP_RSVD_C, OP_RSVD_A));
	endfunction

	// request side
	always @(posedge clk or negedge arst_n) begin
		logic taken;
		logic busy;
		int outstanding;
		logic calm;
		sched_cmd_t cmd;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			taken = req_valid && req_ready;
			busy = req_valid && !req_ready;
			if (taken) begin
				expected_rsps.push_back(predict_outcome(req));
				sent_cnt <= sent_cnt + 1;
			end
			outstanding = sent_cnt + int'(taken) - recv_cnt;
			calm = (sent_cnt >= CALM_LO) && (sent_cnt < CALM_HI);
			if (!busy) begin
				if (pending_cmds.size() == 0) begin
					req_valid <= 1'b0;
				end else if (pending_cmds[0].drain && outstanding != 0) begin
					req_valid <= 1'b0;
				end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
					req_valid <= 1'b0;
				end else begin
					cmd = pending_cmds.pop_front();
					req <= cmd.r;
					req_valid <= 1'b1;
				end
			end
		end
	end

	// response side
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		logic calm;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				recv_cnt <= recv_cnt + 1;
				if (expected_rsps.size() == 0) begin
					$error("response beat with nothing expected: %h", rsp);
					mismatches++;
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp.status !== exp_rsp.status) begin
						$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
						mismatches++;
					end
					if (rsp.running_thread !== exp_rsp.running_thread) begin
						$error("running_thread: expected %0d, got %0d",
							exp_rsp.running_thread, rsp.running_thread);
						mismatches++;
					end
					if (rsp.spawned_thread !== exp_rsp.spawned_thread) begin
						$error("spawned_thread: expected %0d, got %0d",
							exp_rsp.spawned_thread, rsp.spawned_thread);
						mismatches++;
					end
					if (rsp.switched !== exp_rsp.switched) begin
						$error("switched: expected %0d, got %0d",
							exp_rsp.switched, rsp.switched);
						mismatches++;
					end
				end
			end
			calm = (recv_cnt >= CALM_LO) && (recv_cnt < CALM_HI);
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (!hold_done && recv_cnt >= HOLD_AT) begin
				hold_left <= HOLD_LEN;
				hold_done <= 1'b1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		sched_clear();

		// empty ready queue: yield runs on, finish and blocking lock refused
		push_cmd(OP_YIELD, 2'd0, 1'b0);
		push_cmd(OP_FINISH, 2'd0, 1'b0);
		push_cmd(OP_LOCK, 2'd3, 1'b0);
		push_cmd(OP_LOCK, 2'd3, 1'b0);
		push_cmd(OP_UNLOCK, 2'd3, 1'b0);
		// fill every slot, then one spawn too many
		for (int i = 0; i <= NUM_THREADS; i++) begin
			push_cmd(OP_SPAWN, 2'(i), 1'b0);
		end
		// contention and hand-over on one mutex
		push_cmd(OP_LOCK, 2'd0, 1'b0);
		push_cmd(OP_LOCK, 2'd0, 1'b0);
		push_cmd(OP_LOCK, 2'd0, 1'b0);
		push_cmd(OP_UNLOCK, 2'd0, 1'b0);
		push_cmd(OP_UNLOCK, 2'd0, 1'b0);
		push_cmd(OP_UNLOCK, 2'd0, 1'b0);
		push_cmd(OP_YIELD, 2'd2, 1'b0);
		push_cmd(OP_RSVD_A, 2'd1, 1'b0);
		push_cmd(OP_RSVD_B, 2'd2, 1'b0);
		push_cmd(OP_RSVD_C, 2'd3, 1'b0);
		// drain the ready queue, initial thread finishing on the way
		for (int i = 0; i < NUM_THREADS + 1; i++) begin
			push_cmd(OP_FINISH, 2'd1, 1'b0);
		end
		push_cmd(OP_SPAWN, 2'd3, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			push_cmd(pick_op(),
				($urandom_range(99) < 70) ? 2'($urandom_range(1)) : 2'($urandom_range(3)),
				i == RANDOM_ITEMS / 2);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_cmds.size() != 0 || req_valid || recv_cnt != sent_cnt) begin
			@(negedge clk);
		end
		repeat (TRAIL_CYCLES) @(posedge clk);

		if (expected_rsps.size() != 0) begin
			$error("%0d response beats never arrived", expected_rsps.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
